// ===== rtl/agcwf_pkg.sv =====
// agcwf_pkg: shared types and constants for the audio gain stage
// overflow mode codes, register indexes and fold constants; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package agcwf_pkg;

  typedef enum logic [1:0] {
    MODE_CLIP     = 2'd0,
    MODE_WRAP     = 2'd1,
    MODE_FOLD     = 2'd2,
    MODE_CLIP_ALT = 2'd3
  } ovf_mode_t;

  typedef enum logic {
    REG_GAIN = 1'b0,
    REG_MODE = 1'b1
  } cfg_reg_t;

  localparam int SAMPLE_W = 16;
  localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] S16_MIN = 16'sh8000;
  localparam logic [16:0] FOLD_PERIOD = 17'd131070;
  localparam logic [16:0] FOLD_SPAN   = 17'd65535;
  localparam logic [16:0] DIGIT_MOD   = 17'd65535;

endpackage

`default_nettype wire

// ===== rtl/audio_gain_clip_wrap_fold.sv =====
// audio_gain_clip_wrap_fold: signed 16-bit sample times unsigned fixed-point gain
// with clip, wrap or fold handling of out-of-range results; uses agcwf_pkg
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   config: write gain (index 0) or overflow_mode (index 1) with cfg_we,
//   cfg_index and cfg_data; writes take effect at the next edge; user writes
//   must be made only while no sample is in flight; the block does not check it.
//   input: a sample transfer happens at each edge with start high and busy
//   low; busy is always low, so a sample can be sent in every cycle.
//   output: each sample gives exactly one result on sample_out and last_out,
//   shown for one cycle with out_valid high; the receiver cannot stall.
//   pipeline: the result passes the input register, multiply, range handling
//   with mod-65535 digit sum, and fold finish, each of them registered.
//   throughput: one sample per cycle, set by the four-stage pipeline with
//   one multiplier.
//   reset: synchronous rst empties the pipeline, sets gain to 1.0 and the
//   overflow mode to clip.

module audio_gain_clip_wrap_fold
  import agcwf_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 16,
  parameter int GAIN_INT_BITS  = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      cfg_we,
  input  wire logic                                      cfg_index,
  input  wire logic [GAIN_INT_BITS+GAIN_FRAC_BITS-1:0]   cfg_data,
  input  wire logic                                      start,
  output logic                                           busy,
  input  wire logic signed [SAMPLE_W-1:0]                sample_in,
  input  wire logic                                      gap,
  input  wire logic                                      last_in,
  output logic                                           out_valid,
  output logic signed [SAMPLE_W-1:0]                     sample_out,
  output logic                                           last_out
);

  localparam int GW   = GAIN_INT_BITS + GAIN_FRAC_BITS;
  localparam int PW   = SAMPLE_W + GW;
  localparam int QW   = SAMPLE_W + GAIN_INT_BITS;
  localparam int WW   = QW + 2;
  localparam int AW   = WW - 1;
  localparam int ND   = (AW + 15) / 16;
  localparam int SW   = 16 + $clog2(ND + 1);
  localparam longint unsigned OFS_L =
    ((64'd1 << (QW - 1)) / 64'd131070 + 64'd1) * 64'd131070;
  localparam logic [WW-1:0] FOLD_OFS = WW'(OFS_L);
  localparam logic [WW-1:0] HALF_OFS = WW'(32768);

  // config registers
  logic [GW-1:0] gain;
  ovf_mode_t     mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GW'(1) << GAIN_FRAC_BITS;
      mode <= MODE_CLIP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN: gain <= cfg_data;
        REG_MODE: mode <= ovf_mode_t'(cfg_data[1:0]);
        default:  ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage a: input register
  logic                       valid_a;
  logic signed [SAMPLE_W-1:0] sample_a;
  logic                       gap_a;
  logic                       last_a;

  always_ff @(posedge clk) begin
    if (rst) valid_a <= 1'b0;
    else     valid_a <= start && !busy;
    sample_a <= sample_in;
    gap_a    <= gap;
    last_a   <= last_in;
  end

  // stage b: magnitude times gain
  logic [SAMPLE_W-1:0]        mag_a;
  logic [PW-1:0]              prod_a;
  logic                       valid_b;
  logic [QW-1:0]              q_b;
  logic                       neg_b;
  logic signed [SAMPLE_W-1:0] sample_b;
  logic                       gap_b;
  logic                       last_b;

  always_comb begin
    mag_a  = sample_a[SAMPLE_W-1] ? SAMPLE_W'(-sample_a) : SAMPLE_W'(sample_a);
    prod_a = PW'(mag_a) * PW'(gain);
  end

  always_ff @(posedge clk) begin
    if (rst) valid_b <= 1'b0;
    else     valid_b <= valid_a;
    q_b      <= prod_a[GAIN_FRAC_BITS +: QW];
    neg_b    <= sample_a[SAMPLE_W-1];
    sample_b <= sample_a;
    gap_b    <= gap_a;
    last_b   <= last_a;
  end

  // stage c: clip, wrap, gap and fold digit sum
  logic signed [QW:0]         v_b;
  logic [WW-1:0]              w_b;
  logic [ND*16-1:0]           a_b;
  logic [SW-1:0]              dsum_b;
  logic [16:0]                s2_b;
  logic signed [SAMPLE_W-1:0] res_b;

  always_comb begin
    v_b = neg_b ? -$signed({1'b0, q_b}) : $signed({1'b0, q_b});
    w_b = WW'(v_b) + HALF_OFS + FOLD_OFS;
    a_b = (ND*16)'(w_b[WW-1:1]);
    dsum_b = '0;
    for (int i = 0; i < ND; i++) begin
      dsum_b = dsum_b + SW'(a_b[i*16 +: 16]);
    end
    s2_b = 17'(dsum_b[15:0]) + 17'(dsum_b[SW-1:16]);
    if (gap_b) begin
      res_b = sample_b;
    end else if (mode == MODE_WRAP) begin
      res_b = v_b[SAMPLE_W-1:0];
    end else if (neg_b) begin
      res_b = (q_b > QW'(32768)) ? S16_MIN : v_b[SAMPLE_W-1:0];
    end else begin
      res_b = (q_b > QW'(32767)) ? S16_MAX : v_b[SAMPLE_W-1:0];
    end
  end

  logic                       valid_c;
  logic                       fold_c;
  logic [16:0]                s2_c;
  logic                       lsb_c;
  logic signed [SAMPLE_W-1:0] res_c;
  logic                       last_c;

  always_ff @(posedge clk) begin
    if (rst) valid_c <= 1'b0;
    else     valid_c <= valid_b;
    fold_c <= !gap_b && (mode == MODE_FOLD);
    s2_c   <= s2_b;
    lsb_c  <= w_b[0];
    res_c  <= res_b;
    last_c <= last_b;
  end

  // stage d: finish fold, output register
  logic [15:0]                m_c;
  logic [16:0]                r_c;
  logic [16:0]                rf_c;
  logic signed [SAMPLE_W-1:0] out_c;

  always_comb begin
    m_c   = (s2_c >= DIGIT_MOD) ? 16'(s2_c - DIGIT_MOD) : s2_c[15:0];
    r_c   = {m_c, lsb_c};
    rf_c  = (r_c > FOLD_SPAN) ? (FOLD_PERIOD - r_c) : r_c;
    out_c = fold_c ? $signed(rf_c[15:0] ^ 16'h8000) : res_c;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= valid_c;
    sample_out <= out_c;
    last_out   <= last_c;
  end

  // checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##4 out_valid)
    else $error("result missing four cycles after transfer");

  a_gap_pass: assert property (@(posedge clk) disable iff (rst)
    (start && gap) |-> ##4 (sample_out == $past(sample_in, 4)))
    else $error("gap sample altered");

  a_last_copy: assert property (@(posedge clk) disable iff (rst)
    start |-> ##4 (last_out == $past(last_in, 4)))
    else $error("last flag not carried");

endmodule

`default_nettype wire
